/* rtl/core/assert_macros.svh */
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/sfpm_pkg.sv */
package sfpm_pkg;

    localparam int unsigned SampleW = 16;
    localparam int unsigned TimeW   = 32;
    localparam int unsigned ModeW   = 3;
    localparam int unsigned CfgIdxW = 4;

    localparam logic [TimeW-1:0] TEMP_HOLD_MS     = 32'd1000;
    localparam logic [TimeW-1:0] PRESSURE_HOLD_MS = 32'd1000;
    localparam logic [TimeW-1:0] CURRENT_HOLD_MS  = 32'd1000;
    localparam logic [TimeW-1:0] VOLTAGE_HOLD_MS  = 32'd1000;

    localparam logic [ModeW-1:0] MODE_OTHER  = 3'd0;
    localparam logic [ModeW-1:0] MODE_PURGE  = 3'd1;
    localparam logic [ModeW-1:0] MODE_WARMUP = 3'd2;
    localparam logic [ModeW-1:0] MODE_RUN    = 3'd3;
    localparam logic [ModeW-1:0] MODE_ALARM  = 3'd4;

    localparam logic [CfgIdxW-1:0] REG_TEMP_HIGH     = 4'd0;
    localparam logic [CfgIdxW-1:0] REG_TEMP_LOW      = 4'd1;
    localparam logic [CfgIdxW-1:0] REG_PRESSURE_HIGH = 4'd2;
    localparam logic [CfgIdxW-1:0] REG_PRESSURE_LOW  = 4'd3;
    localparam logic [CfgIdxW-1:0] REG_CURRENT_HIGH  = 4'd4;
    localparam logic [CfgIdxW-1:0] REG_CURRENT_LOW   = 4'd5;
    localparam logic [CfgIdxW-1:0] REG_VOLTAGE_HIGH  = 4'd6;
    localparam logic [CfgIdxW-1:0] REG_VOLTAGE_LOW   = 4'd7;

    localparam logic signed [SampleW-1:0] LIMIT_HIGH_RST = 16'sh7fff;
    localparam logic signed [SampleW-1:0] LIMIT_LOW_RST  = 16'sh8000;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_TEMP     = 3'd1,
        KIND_PRESSURE = 3'd2,
        KIND_CURRENT  = 3'd3,
        KIND_VOLTAGE  = 3'd4
    } t_alarm;

    typedef enum logic [1:0] {
        SLOT_TEMP     = 2'd0,
        SLOT_CURRENT  = 2'd1,
        SLOT_VOLTAGE  = 2'd2,
        SLOT_PRESSURE = 2'd3
    } t_slot;

    typedef struct packed {
        logic signed [SampleW-1:0] temp_high;
        logic signed [SampleW-1:0] temp_low;
        logic signed [SampleW-1:0] pressure_high;
        logic signed [SampleW-1:0] pressure_low;
        logic signed [SampleW-1:0] current_high;
        logic signed [SampleW-1:0] current_low;
        logic signed [SampleW-1:0] voltage_high;
        logic signed [SampleW-1:0] voltage_low;
    } t_limits;

    typedef struct packed {
        logic signed [SampleW-1:0] temperature;
        logic signed [SampleW-1:0] pressure;
        logic signed [SampleW-1:0] load_current;
        logic signed [SampleW-1:0] stack_voltage;
        logic [TimeW-1:0]          time_now;
        logic [ModeW-1:0]          fc_mode;
    } t_sample;

    typedef struct packed {
        logic temp_bad;
        logic pressure_bad_entry;
        logic pressure_bad_hold;
        logic current_bad;
        logic voltage_bad;
    } t_faults;

endpackage

/* rtl/core/sfpm_cfg_regs.sv */
module sfpm_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sfpm_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic signed [sfpm_pkg::SampleW-1:0] i_cfg_data,
    output sfpm_pkg::t_limits                   o_limits
);

    sfpm_pkg::t_limits r_limits;
    sfpm_pkg::t_limits n_limits;

    assign o_cfg_ready = 1'b1;
    assign o_limits    = r_limits;

    always_comb begin
        n_limits = r_limits;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sfpm_pkg::REG_TEMP_HIGH:     n_limits.temp_high     = i_cfg_data;
                sfpm_pkg::REG_TEMP_LOW:      n_limits.temp_low      = i_cfg_data;
                sfpm_pkg::REG_PRESSURE_HIGH: n_limits.pressure_high = i_cfg_data;
                sfpm_pkg::REG_PRESSURE_LOW:  n_limits.pressure_low  = i_cfg_data;
                sfpm_pkg::REG_CURRENT_HIGH:  n_limits.current_high  = i_cfg_data;
                sfpm_pkg::REG_CURRENT_LOW:   n_limits.current_low   = i_cfg_data;
                sfpm_pkg::REG_VOLTAGE_HIGH:  n_limits.voltage_high  = i_cfg_data;
                sfpm_pkg::REG_VOLTAGE_LOW:   n_limits.voltage_low   = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.temp_high     <= sfpm_pkg::LIMIT_HIGH_RST;
            r_limits.temp_low      <= sfpm_pkg::LIMIT_LOW_RST;
            r_limits.pressure_high <= sfpm_pkg::LIMIT_HIGH_RST;
            r_limits.pressure_low  <= sfpm_pkg::LIMIT_LOW_RST;
            r_limits.current_high  <= sfpm_pkg::LIMIT_HIGH_RST;
            r_limits.current_low   <= sfpm_pkg::LIMIT_LOW_RST;
            r_limits.voltage_high  <= sfpm_pkg::LIMIT_HIGH_RST;
            r_limits.voltage_low   <= sfpm_pkg::LIMIT_LOW_RST;
        end else begin
            r_limits <= n_limits;
        end
    end

endmodule

/* rtl/core/sfpm_classify.sv */
module sfpm_classify (
    input  sfpm_pkg::t_sample i_sample,
    input  sfpm_pkg::t_limits i_limits,
    output sfpm_pkg::t_faults o_faults
);

    logic pressure_high;
    logic pressure_low;
    logic mode_entry;
    logic mode_hold;

    assign pressure_high = i_sample.pressure >= i_limits.pressure_high;
    assign pressure_low  = i_sample.pressure <= i_limits.pressure_low;

    // warmup qualifies low pressure on entry only
    assign mode_hold  = (i_sample.fc_mode == sfpm_pkg::MODE_PURGE) ||
                        (i_sample.fc_mode == sfpm_pkg::MODE_RUN);
    assign mode_entry = mode_hold || (i_sample.fc_mode == sfpm_pkg::MODE_WARMUP);

    assign o_faults.temp_bad = (i_sample.temperature >= i_limits.temp_high) ||
                               (i_sample.temperature <= i_limits.temp_low);
    assign o_faults.pressure_bad_entry = pressure_high || (pressure_low && mode_entry);
    assign o_faults.pressure_bad_hold  = pressure_high || (pressure_low && mode_hold);
    assign o_faults.current_bad = (i_sample.load_current >= i_limits.current_high) ||
                                  (i_sample.load_current <= i_limits.current_low);
    assign o_faults.voltage_bad = (i_sample.stack_voltage >= i_limits.voltage_high) ||
                                  (i_sample.stack_voltage <= i_limits.voltage_low);

endmodule

/* rtl/core/sfpm_tracker.sv */
`include "assert_macros.svh"

module sfpm_tracker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  sfpm_pkg::t_faults               i_faults,
    input  logic [sfpm_pkg::TimeW-1:0]      i_time_now,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [2:0]                      o_pending_alarm,
    output logic                            o_trip,
    output logic [1:0]                      o_error_slot
);

    sfpm_pkg::t_alarm             r_alarm_kind;
    sfpm_pkg::t_alarm             n_alarm_kind;
    logic [sfpm_pkg::TimeW-1:0]   r_fault_start;
    logic [sfpm_pkg::TimeW-1:0]   n_fault_start;
    logic                         r_out_valid;
    sfpm_pkg::t_alarm             r_out_alarm;
    logic                         r_out_trip;
    sfpm_pkg::t_slot              r_out_slot;
    logic                         n_trip;
    sfpm_pkg::t_slot              n_slot;
    logic                         still_bad;
    logic [sfpm_pkg::TimeW-1:0]   hold_ms;
    sfpm_pkg::t_slot              hold_slot;
    logic [sfpm_pkg::TimeW-1:0]   elapsed;
    logic                         advance;

    assign o_ready = !r_out_valid || i_out_ready;
    assign advance = i_valid && o_ready;

    // wraps modulo 2^32 by construction
    assign elapsed = i_time_now - r_fault_start;

    always_comb begin
        unique case (r_alarm_kind)
            sfpm_pkg::KIND_TEMP: begin
                still_bad = i_faults.temp_bad;
                hold_ms   = sfpm_pkg::TEMP_HOLD_MS;
                hold_slot = sfpm_pkg::SLOT_TEMP;
            end
            sfpm_pkg::KIND_PRESSURE: begin
                still_bad = i_faults.pressure_bad_hold;
                hold_ms   = sfpm_pkg::PRESSURE_HOLD_MS;
                hold_slot = sfpm_pkg::SLOT_PRESSURE;
            end
            sfpm_pkg::KIND_CURRENT: begin
                still_bad = i_faults.current_bad;
                hold_ms   = sfpm_pkg::CURRENT_HOLD_MS;
                hold_slot = sfpm_pkg::SLOT_CURRENT;
            end
            sfpm_pkg::KIND_VOLTAGE: begin
                still_bad = i_faults.voltage_bad;
                hold_ms   = sfpm_pkg::VOLTAGE_HOLD_MS;
                hold_slot = sfpm_pkg::SLOT_VOLTAGE;
            end
            default: begin
                still_bad = 1'b0;
                hold_ms   = '0;
                hold_slot = sfpm_pkg::SLOT_TEMP;
            end
        endcase
    end

    always_comb begin
        n_alarm_kind  = r_alarm_kind;
        n_fault_start = r_fault_start;
        n_trip        = 1'b0;
        n_slot        = sfpm_pkg::SLOT_TEMP;
        if (r_alarm_kind == sfpm_pkg::KIND_NONE) begin
            // priority: temperature, pressure, current, voltage
            n_fault_start = i_time_now;
            if (i_faults.temp_bad) begin
                n_alarm_kind = sfpm_pkg::KIND_TEMP;
            end else if (i_faults.pressure_bad_entry) begin
                n_alarm_kind = sfpm_pkg::KIND_PRESSURE;
            end else if (i_faults.current_bad) begin
                n_alarm_kind = sfpm_pkg::KIND_CURRENT;
            end else if (i_faults.voltage_bad) begin
                n_alarm_kind = sfpm_pkg::KIND_VOLTAGE;
            end else begin
                n_fault_start = r_fault_start;
            end
        end else if (!still_bad) begin
            n_alarm_kind = sfpm_pkg::KIND_NONE;
        end else if (elapsed >= hold_ms) begin
            n_trip = 1'b1;
            n_slot = hold_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_kind  <= sfpm_pkg::KIND_NONE;
            r_fault_start <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (advance) begin
                r_alarm_kind  <= n_alarm_kind;
                r_fault_start <= n_fault_start;
            end
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_alarm <= n_alarm_kind;
            r_out_trip  <= n_trip;
            r_out_slot  <= n_slot;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pending_alarm = r_out_alarm;
    assign o_trip          = r_out_trip;
    assign o_error_slot    = r_out_slot;

    `ASSERT_IMP(a_trip_has_alarm, i_clk, i_rst_n, r_out_valid && r_out_trip,
                r_out_alarm != sfpm_pkg::KIND_NONE)
    `ASSERT_IMP(a_no_trip_slot_zero, i_clk, i_rst_n, r_out_valid && !r_out_trip,
                r_out_slot == sfpm_pkg::SLOT_TEMP)
    `ASSERT_NEXT(a_latch_never_trips, i_clk, i_rst_n,
                 advance && r_alarm_kind == sfpm_pkg::KIND_NONE, !r_out_trip)
    `ASSERT_NEXT(a_start_held, i_clk, i_rst_n,
                 r_alarm_kind != sfpm_pkg::KIND_NONE, $stable(r_fault_start))

endmodule

/* rtl/core/sensor_fault_persistence_monitor_top.sv */
// channel   direction  handshake                payload
// in        sink       i_in_valid / o_in_ready   temperature, pressure, load_current,
//                                               stack_voltage, time_now, fc_mode
// out       source     o_out_valid / i_out_ready pending_alarm, trip, error_slot
// cfg       sink       i_cfg_valid / o_cfg_ready cfg_index, cfg_data
//
// one sample set a cycle while the output is not stalled; each result passes the
// input register, then window compares, alarm update and elapsed-time compare
// into the result register
// synchronous active-low reset: thresholds to their widest window, no alarm pending
// a stalled output holds both stages; the input side keeps flowing while the
// result register is free or being drained
module sensor_fault_persistence_monitor_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [sfpm_pkg::SampleW-1:0] i_temperature,
    input  logic signed [sfpm_pkg::SampleW-1:0] i_pressure,
    input  logic signed [sfpm_pkg::SampleW-1:0] i_load_current,
    input  logic signed [sfpm_pkg::SampleW-1:0] i_stack_voltage,
    input  logic [sfpm_pkg::TimeW-1:0]          i_time_now,
    input  logic [sfpm_pkg::ModeW-1:0]          i_fc_mode,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [2:0]                          o_pending_alarm,
    output logic                                o_trip,
    output logic [1:0]                          o_error_slot,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sfpm_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic signed [sfpm_pkg::SampleW-1:0] i_cfg_data
);

    sfpm_pkg::t_limits limits;
    sfpm_pkg::t_faults faults;
    sfpm_pkg::t_sample r_sample;
    logic              r_sample_valid;
    logic              trk_ready;

    assign o_in_ready = !r_sample_valid || trk_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_sample_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_sample.temperature   <= i_temperature;
            r_sample.pressure      <= i_pressure;
            r_sample.load_current  <= i_load_current;
            r_sample.stack_voltage <= i_stack_voltage;
            r_sample.time_now      <= i_time_now;
            r_sample.fc_mode       <= i_fc_mode;
        end
    end

    sfpm_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_limits    (limits)
    );

    sfpm_classify u_classify (
        .i_sample (r_sample),
        .i_limits (limits),
        .o_faults (faults)
    );

    sfpm_tracker u_tracker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_sample_valid),
        .o_ready         (trk_ready),
        .i_faults        (faults),
        .i_time_now      (r_sample.time_now),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pending_alarm (o_pending_alarm),
        .o_trip          (o_trip),
        .o_error_slot    (o_error_slot)
    );

endmodule
